@@ design/tjrd_pkg.sv @@
// tjrd_pkg: shared constants, codes and control types for the radial dead zone joystick.
// Used by the controller, the datapath, the top level and the checker.
package tjrd_pkg;

  localparam int COORD_BITS_DEF     = 13;
  localparam int AXIS_FRAC_BITS_DEF = 14;
  localparam int RADIUS_W           = 12;
  localparam int DZ_W               = 15;
  localparam int STICK_IN_W         = 16;
  localparam int OP_W               = 3;
  localparam int PADDR_W            = 4;

  localparam logic [RADIUS_W-1:0] MAX_RADIUS_RST = 12'd100;
  localparam logic [DZ_W-1:0]     DEAD_ZONE_RST  = 15'd1638;

  localparam logic [OP_W-1:0] OP_START = 3'd0;
  localparam logic [OP_W-1:0] OP_MOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_END   = 3'd2;
  localparam logic [OP_W-1:0] OP_STICK = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

  localparam logic [1:0] REG_MAX_RADIUS = 2'd0;
  localparam logic [1:0] REG_DEAD_ZONE  = 2'd1;
  localparam logic [1:0] REG_TOUCH_MODE = 2'd2;

  localparam logic [3:0] CMD_NOP   = 4'd0;
  localparam logic [3:0] CMD_EVENT = 4'd1;
  localparam logic [3:0] CMD_SQ1   = 4'd2;
  localparam logic [3:0] CMD_SQ2   = 4'd3;
  localparam logic [3:0] CMD_SQ3   = 4'd4;
  localparam logic [3:0] CMD_SQRT  = 4'd5;
  localparam logic [3:0] CMD_DVI   = 4'd6;
  localparam logic [3:0] CMD_DIV   = 4'd7;
  localparam logic [3:0] CMD_DVE   = 4'd8;
  localparam logic [3:0] CMD_DZ1   = 4'd9;
  localparam logic [3:0] CMD_DZ2   = 4'd10;

  typedef struct packed {
    logic [3:0] code;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
  } dp_status_t;

endpackage

@@ design/tjrd_ctrl.sv @@
// tjrd_ctrl: sequencer for events and the tick computation (root, divide, dead zone).
// Depends on tjrd_pkg; drives the datapath through dp_cmd_t.
module tjrd_ctrl #(
  parameter int COORD_BITS     = tjrd_pkg::COORD_BITS_DEF,
  parameter int AXIS_FRAC_BITS = tjrd_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [tjrd_pkg::OP_W-1:0] in_op,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     touch_mode,
  input  tjrd_pkg::dp_status_t     status,
  output tjrd_pkg::dp_cmd_t        cmd
);

  localparam int RW  = COORD_BITS + 1;
  localparam int NW  = COORD_BITS + AXIS_FRAC_BITS;
  localparam int CTW = $clog2(NW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ1  = 4'd1;
  localparam logic [3:0] S_SQ2  = 4'd2;
  localparam logic [3:0] S_SQ3  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_DVI  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_DVE  = 4'd7;
  localparam logic [3:0] S_DZ1  = 4'd8;
  localparam logic [3:0] S_DZ2  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]     state_r, state_nxt;
  logic [CTW-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.code      = tjrd_pkg::CMD_NOP;
    cmd.out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.code = tjrd_pkg::CMD_EVENT;
          if (in_op == tjrd_pkg::OP_TICK) begin
            if (!touch_mode) state_nxt = S_DZ1;
            else if (status.active) state_nxt = S_SQ1;
            else state_nxt = S_FIN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SQ1: begin
        cmd.code  = tjrd_pkg::CMD_SQ1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.code  = tjrd_pkg::CMD_SQ2;
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        cmd.code  = tjrd_pkg::CMD_SQ3;
        cnt_nxt   = CTW'(RW - 1);
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.code = tjrd_pkg::CMD_SQRT;
        if (cnt_r == '0) state_nxt = S_DVI;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_DVI: begin
        cmd.code  = tjrd_pkg::CMD_DVI;
        cnt_nxt   = CTW'(NW - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.code = tjrd_pkg::CMD_DIV;
        if (cnt_r == '0) state_nxt = S_DVE;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_DVE: begin
        cmd.code  = tjrd_pkg::CMD_DVE;
        state_nxt = S_DZ1;
      end
      S_DZ1: begin
        cmd.code  = tjrd_pkg::CMD_DZ1;
        state_nxt = S_DZ2;
      end
      S_DZ2: begin
        cmd.code  = tjrd_pkg::CMD_DZ2;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/tjrd_dp.sv @@
// tjrd_dp: joystick state, squares, bit-serial root, two-lane restoring divider, dead zone.
// Depends on tjrd_pkg; steered by tjrd_ctrl commands.
module tjrd_dp #(
  parameter int COORD_BITS     = tjrd_pkg::COORD_BITS_DEF,
  parameter int AXIS_FRAC_BITS = tjrd_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tjrd_pkg::dp_cmd_t                     cmd,
  output tjrd_pkg::dp_status_t                  status,
  input  logic [tjrd_pkg::OP_W-1:0]             in_op,
  input  logic [COORD_BITS-1:0]                 in_pos_x,
  input  logic [COORD_BITS-1:0]                 in_pos_y,
  input  logic signed [tjrd_pkg::STICK_IN_W-1:0] in_stick_in_x,
  input  logic signed [tjrd_pkg::STICK_IN_W-1:0] in_stick_in_y,
  input  logic [tjrd_pkg::RADIUS_W-1:0]         max_radius,
  input  logic [tjrd_pkg::DZ_W-1:0]             dead_zone,
  output logic signed [AXIS_FRAC_BITS+1:0]      out_stick_out_x,
  output logic signed [AXIS_FRAC_BITS+1:0]      out_stick_out_y,
  output logic                                  out_pressed,
  output logic                                  out_touch_active
);

  localparam int CB   = COORD_BITS;
  localparam int AFB  = AXIS_FRAC_BITS;
  localparam int AW   = AFB + 2;
  localparam int SW   = 2 * CB + 2;
  localparam int RW   = CB + 1;
  localparam int RRW  = 2 * tjrd_pkg::RADIUS_W;
  localparam int CMPW = (SW > RRW) ? SW : RRW;
  localparam int DVW  = (RW > tjrd_pkg::RADIUS_W) ? RW : tjrd_pkg::RADIUS_W;
  localparam int NW   = CB + AFB;
  localparam int EW   = ((AW > tjrd_pkg::STICK_IN_W) ? AW : tjrd_pkg::STICK_IN_W) + 1;
  localparam int DZ2W = 2 * tjrd_pkg::DZ_W;
  localparam int MW   = ((2 * AW + 1) > DZ2W) ? (2 * AW + 1) : DZ2W;
  localparam logic signed [EW-1:0] ONE_E = EW'(1) <<< AFB;

  logic [CB-1:0]        start_x_r, start_y_r, cur_x_r, cur_y_r;
  logic signed [AW-1:0] axis_x_r, axis_y_r;
  logic                 pressed_r, active_r;

  logic signed [CB:0]   dx_r, dy_r;
  logic [SW-1:0]        sqx_r, d2_r, sq_src_r;
  logic [RRW-1:0]       rr_r;
  logic [RW+1:0]        sq_rem_r;
  logic [RW-1:0]        root_r;
  logic [DVW-1:0]       dv_r;
  logic [DVW-1:0]       rem_x_r, rem_y_r;
  logic [NW-1:0]        q_x_r, q_y_r;
  logic [2*AW-1:0]      mag_x_r;
  logic [DZ2W-1:0]      dz2_r;

  logic [tjrd_pkg::RADIUS_W-1:0] radius;
  logic signed [CB:0]   dx, dy;
  logic signed [SW-1:0] sq_a, sq_b;
  logic [RW+1:0]        sq_t, sq_trial;
  logic [DVW:0]         tx, ty;
  logic [CB-1:0]        ax_abs, ay_abs;
  logic [AW-1:0]        qx, qy;
  logic signed [2*AW-1:0] mx, my;
  logic [MW-1:0]        mag;
  logic signed [EW-1:0] sx, sy;
  logic signed [AW-1:0] cx, cy;

  assign radius = (max_radius == '0) ? tjrd_pkg::RADIUS_W'(1) : max_radius;
  assign dx     = $signed({1'b0, cur_x_r}) - $signed({1'b0, start_x_r});
  assign dy     = $signed({1'b0, cur_y_r}) - $signed({1'b0, start_y_r});
  assign sq_a   = dx_r * dx_r;
  assign sq_b   = dy_r * dy_r;

  assign sq_t     = {sq_rem_r[RW-1:0], sq_src_r[SW-1:SW-2]};
  assign sq_trial = {root_r, 2'b01};

  assign tx = {rem_x_r, q_x_r[NW-1]};
  assign ty = {rem_y_r, q_y_r[NW-1]};

  assign ax_abs = dx_r[CB] ? CB'(-dx_r) : dx_r[CB-1:0];
  assign ay_abs = dy_r[CB] ? CB'(-dy_r) : dy_r[CB-1:0];
  assign qx     = AW'(q_x_r);
  assign qy     = AW'(q_y_r);

  assign mx  = axis_x_r * axis_x_r;
  assign my  = axis_y_r * axis_y_r;
  assign mag = MW'(mag_x_r) + MW'(unsigned'(my));

  assign sx = {{(EW-tjrd_pkg::STICK_IN_W){in_stick_in_x[tjrd_pkg::STICK_IN_W-1]}}, in_stick_in_x};
  assign sy = {{(EW-tjrd_pkg::STICK_IN_W){in_stick_in_y[tjrd_pkg::STICK_IN_W-1]}}, in_stick_in_y};
  assign cx = (sx > ONE_E) ? AW'(ONE_E) : (sx < -ONE_E) ? AW'(-ONE_E) : AW'(sx);
  assign cy = (sy > ONE_E) ? AW'(ONE_E) : (sy < -ONE_E) ? AW'(-ONE_E) : AW'(sy);

  assign status.active = active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      axis_x_r  <= '0;
      axis_y_r  <= '0;
      pressed_r <= 1'b0;
      active_r  <= 1'b0;
    end else begin
      case (cmd.code)
        tjrd_pkg::CMD_EVENT: begin
          case (in_op)
            tjrd_pkg::OP_START: begin
              if (!active_r) begin
                start_x_r <= in_pos_x;
                start_y_r <= in_pos_y;
                cur_x_r   <= in_pos_x;
                cur_y_r   <= in_pos_y;
                active_r  <= 1'b1;
                pressed_r <= 1'b1;
              end
            end
            tjrd_pkg::OP_MOVE: begin
              if (active_r) begin
                cur_x_r <= in_pos_x;
                cur_y_r <= in_pos_y;
              end
            end
            tjrd_pkg::OP_END: begin
              active_r  <= 1'b0;
              pressed_r <= 1'b0;
              axis_x_r  <= '0;
              axis_y_r  <= '0;
            end
            tjrd_pkg::OP_STICK: begin
              axis_x_r <= cx;
              axis_y_r <= cy;
            end
            default: ;
          endcase
        end
        tjrd_pkg::CMD_DVE: begin
          axis_x_r <= dx_r[CB] ? -$signed(qx) : $signed(qx);
          axis_y_r <= dy_r[CB] ? -$signed(qy) : $signed(qy);
        end
        tjrd_pkg::CMD_DZ2: begin
          if (mag < MW'(dz2_r)) begin
            axis_x_r  <= '0;
            axis_y_r  <= '0;
            pressed_r <= 1'b0;
          end else begin
            pressed_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // scratch registers of the tick computation
  always_ff @(posedge clk) begin
    case (cmd.code)
      tjrd_pkg::CMD_SQ1: begin
        dx_r <= dx;
        dy_r <= dy;
        rr_r <= radius * radius;
      end
      tjrd_pkg::CMD_SQ2: sqx_r <= unsigned'(sq_a);
      tjrd_pkg::CMD_SQ3: begin
        d2_r     <= sqx_r + unsigned'(sq_b);
        sq_src_r <= sqx_r + unsigned'(sq_b);
        sq_rem_r <= '0;
        root_r   <= '0;
      end
      tjrd_pkg::CMD_SQRT: begin
        sq_src_r <= sq_src_r << 2;
        if (sq_t >= sq_trial) begin
          sq_rem_r <= sq_t - sq_trial;
          root_r   <= {root_r[RW-2:0], 1'b1};
        end else begin
          sq_rem_r <= sq_t;
          root_r   <= {root_r[RW-2:0], 1'b0};
        end
      end
      tjrd_pkg::CMD_DVI: begin
        dv_r    <= (CMPW'(d2_r) > CMPW'(rr_r)) ? DVW'(root_r) : DVW'(radius);
        rem_x_r <= '0;
        rem_y_r <= '0;
        q_x_r   <= {ax_abs, AFB'(0)};
        q_y_r   <= {ay_abs, AFB'(0)};
      end
      tjrd_pkg::CMD_DIV: begin
        if (tx >= {1'b0, dv_r}) begin
          rem_x_r <= DVW'(tx - {1'b0, dv_r});
          q_x_r   <= {q_x_r[NW-2:0], 1'b1};
        end else begin
          rem_x_r <= DVW'(tx);
          q_x_r   <= {q_x_r[NW-2:0], 1'b0};
        end
        if (ty >= {1'b0, dv_r}) begin
          rem_y_r <= DVW'(ty - {1'b0, dv_r});
          q_y_r   <= {q_y_r[NW-2:0], 1'b1};
        end else begin
          rem_y_r <= DVW'(ty);
          q_y_r   <= {q_y_r[NW-2:0], 1'b0};
        end
      end
      tjrd_pkg::CMD_DZ1: begin
        mag_x_r <= unsigned'(mx);
        dz2_r   <= dead_zone * dead_zone;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_stick_out_x  <= axis_x_r;
      out_stick_out_y  <= axis_y_r;
      out_pressed      <= pressed_r;
      out_touch_active <= active_r;
    end
  end

endmodule

@@ design/touch_joystick_radial_deadzone_core.sv @@
// Radial dead zone virtual joystick: APB registers, controller and datapath.
// Events go straight to the FIN state and out_valid; a touch tick with an active touch first runs
// the squares, bit-serial root, restoring divider and dead zone; a stick tick runs the dead zone.
// One word in flight; a new word is taken while the previous result waits.
// Synchronous active-low reset clears state and flags and sets the APB registers to their defaults.
module touch_joystick_radial_deadzone_core #(
  parameter int COORD_BITS     = tjrd_pkg::COORD_BITS_DEF,
  parameter int AXIS_FRAC_BITS = tjrd_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tjrd_pkg::OP_W-1:0]             in_op,
  input  logic [COORD_BITS-1:0]                 in_pos_x,
  input  logic [COORD_BITS-1:0]                 in_pos_y,
  input  logic signed [tjrd_pkg::STICK_IN_W-1:0] in_stick_in_x,
  input  logic signed [tjrd_pkg::STICK_IN_W-1:0] in_stick_in_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [AXIS_FRAC_BITS+1:0]      out_stick_out_x,
  output logic signed [AXIS_FRAC_BITS+1:0]      out_stick_out_y,
  output logic                                  out_pressed,
  output logic                                  out_touch_active,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tjrd_pkg::PADDR_W-1:0]          paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  logic [tjrd_pkg::RADIUS_W-1:0] max_radius_r;
  logic [tjrd_pkg::DZ_W-1:0]     dead_zone_r;
  logic                          touch_mode_r;
  tjrd_pkg::dp_cmd_t             cmd;
  tjrd_pkg::dp_status_t          status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_radius_r <= tjrd_pkg::MAX_RADIUS_RST;
      dead_zone_r  <= tjrd_pkg::DEAD_ZONE_RST;
      touch_mode_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        tjrd_pkg::REG_MAX_RADIUS: max_radius_r <= pwdata[tjrd_pkg::RADIUS_W-1:0];
        tjrd_pkg::REG_DEAD_ZONE:  dead_zone_r  <= pwdata[tjrd_pkg::DZ_W-1:0];
        tjrd_pkg::REG_TOUCH_MODE: touch_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tjrd_pkg::REG_MAX_RADIUS: prdata = 32'(max_radius_r);
      tjrd_pkg::REG_DEAD_ZONE:  prdata = 32'(dead_zone_r);
      tjrd_pkg::REG_TOUCH_MODE: prdata = 32'(touch_mode_r);
      default:                  prdata = '0;
    endcase
  end

  tjrd_ctrl #(
    .COORD_BITS     (COORD_BITS),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .touch_mode (touch_mode_r),
    .status     (status),
    .cmd        (cmd)
  );

  tjrd_dp #(
    .COORD_BITS     (COORD_BITS),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_op            (in_op),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_stick_in_x    (in_stick_in_x),
    .in_stick_in_y    (in_stick_in_y),
    .max_radius       (max_radius_r),
    .dead_zone        (dead_zone_r),
    .out_stick_out_x  (out_stick_out_x),
    .out_stick_out_y  (out_stick_out_y),
    .out_pressed      (out_pressed),
    .out_touch_active (out_touch_active)
  );

endmodule

@@ design/tjrd_checker.sv @@
// tjrd_checker: port-level assertions for the joystick core, bound to the top level.
// Depends on tjrd_pkg for default widths.
module tjrd_checker #(
  parameter int AXIS_FRAC_BITS = tjrd_pkg::AXIS_FRAC_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [AXIS_FRAC_BITS+1:0] out_stick_out_x,
  input logic signed [AXIS_FRAC_BITS+1:0] out_stick_out_y
);

  localparam logic signed [AXIS_FRAC_BITS+1:0] ONE = (AXIS_FRAC_BITS+2)'(1) <<< AXIS_FRAC_BITS;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_stick_out_x) && $stable(out_stick_out_y))
    else $error("stalled result word changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stick_out_x <= ONE && out_stick_out_x >= -ONE &&
                  out_stick_out_y <= ONE && out_stick_out_y >= -ONE)
    else $error("axis outside unit range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind touch_joystick_radial_deadzone_core tjrd_checker #(
  .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
) u_tjrd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_stick_out_x (out_stick_out_x),
  .out_stick_out_y (out_stick_out_y)
);
